// ----- hdl/velocity_to_unicycle_command_top_defines.svh -----
// Assertion macros used by the velocity-to-unicycle command top level.
`ifndef VELOCITY_TO_UNICYCLE_COMMAND_TOP_DEFINES_SVH
`define VELOCITY_TO_UNICYCLE_COMMAND_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VUC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("vuc assertion failed");
`define VUC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("vuc assertion failed");
`else
`define VUC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define VUC_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- hdl/vuc_pkg.sv -----
// Constants, types and step functions of the velocity-to-unicycle command pipeline.
package vuc_pkg;

  localparam int CORD_STEPS    = 16;
  localparam int STEPS_PER_STG = 2;
  localparam int CORD_STG      = CORD_STEPS / STEPS_PER_STG;
  localparam int FRONT_LAT     = CORD_STG + 1;
  localparam int EXP_TERMS     = 12;
  localparam int EXP_LAT       = 3 * EXP_TERMS;
  localparam int TOT_LAT       = FRONT_LAT + 2 + EXP_LAT + 3;

  localparam logic signed [24:0] Q20_PI     = 25'sd3294199;
  localparam logic signed [24:0] Q20_TWO_PI = 25'sd6588398;
  localparam logic [31:0]        Q30_ONE    = 32'h4000_0000;
  localparam logic [31:0]        Q30_LN2    = 32'd744261118;
  localparam logic [11:0]        LIN_CAP    = 12'd2048;

  // multiples of ln2 in Q30, 0 through 5
  localparam logic [31:0] KLN2 [6] = '{
    32'd0, 32'd744261118, 32'd1488522236, 32'd2232783354, 32'd2977044472, 32'd3721305590
  };

  localparam logic signed [24:0] ATAN [CORD_STEPS] = '{
    25'sd823550, 25'sd486170, 25'sd256879, 25'sd130396, 25'sd65451, 25'sd32757,
    25'sd16383, 25'sd8192, 25'sd4096, 25'sd2048, 25'sd1024, 25'sd512,
    25'sd256, 25'sd128, 25'sd64, 25'sd32
  };

  typedef enum logic [1:0] {
    CFG_LIN_MAX,
    CFG_LIN_MIN,
    CFG_ANG_MAX,
    CFG_ANG_MIN
  } cfg_idx_t;

  typedef struct packed {
    logic signed [26:0] x;
    logic signed [26:0] y;
    logic signed [24:0] z;
    logic               byp;
  } cord_t;

  typedef struct packed {
    logic [31:0] n;
    logic [32:0] res;
  } isq_t;

  function automatic cord_t cord_step(input cord_t s, input int i);
    cord_t o;
    logic signed [26:0] xs, ys;
    o  = s;
    xs = s.x >>> i;
    ys = s.y >>> i;
    if (s.y > 27'sd0) begin
      o.x = s.x + ys;
      o.y = s.y - xs;
      if (!s.byp) o.z = s.z + ATAN[i];
    end else begin
      o.x = s.x - ys;
      o.y = s.y + xs;
      if (!s.byp) o.z = s.z - ATAN[i];
    end
    return o;
  endfunction

  function automatic isq_t isq_step(input isq_t s, input int i);
    isq_t o;
    logic [32:0] bitv, trial;
    o     = s;
    bitv  = 33'd1 << (30 - 2 * i);
    trial = s.res + bitv;
    if (33'(s.n) >= trial) begin
      o.n   = s.n - trial[31:0];
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // zero max or min passes the value; zero or negative goes to [-max, -min]
  function automatic logic signed [18:0] band_clamp(input logic signed [18:0] v,
                                                    input logic [14:0] mx,
                                                    input logic [14:0] mn);
    logic signed [18:0] hi, lo, o;
    hi = $signed(19'(mx));
    lo = $signed(19'(mn));
    o  = v;
    if (mx != '0 && mn != '0) begin
      if (v > 19'sd0) begin
        if (o < lo) o = lo;
        if (o > hi) o = hi;
      end else begin
        if (o > -lo) o = -lo;
        if (o < -hi) o = -hi;
      end
    end
    return o;
  endfunction

endpackage

// ----- hdl/vuc_cord.sv -----
// Pipelined CORDIC giving the direction of the velocity vector in Q20 radians.
module vuc_cord import vuc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  output logic signed [24:0] dir
);

  cord_t c0;
  cord_t st_r [CORD_STG+1];
  logic signed [26:0] x0, y0;

  assign x0 = {{3{vel_x[15]}}, vel_x, 8'b0};
  assign y0 = {{3{vel_y[15]}}, vel_y, 8'b0};

  // zero y bypasses the rotation; negative x is turned by pi first
  always_comb begin
    c0.x   = x0;
    c0.y   = y0;
    c0.z   = '0;
    c0.byp = (vel_y == '0);
    if (c0.byp) begin
      c0.z = vel_x[15] ? Q20_PI : 25'sd0;
    end else if (vel_x[15]) begin
      c0.z = vel_y[15] ? -Q20_PI : Q20_PI;
      c0.x = -x0;
      c0.y = -y0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= c0;
      for (int s = 1; s <= CORD_STG; s++) begin
        st_r[s] <= cord_step(cord_step(st_r[s-1], STEPS_PER_STG * (s - 1)),
                             STEPS_PER_STG * (s - 1) + 1);
      end
    end
  end

  assign dir = st_r[CORD_STG].z;

endmodule

// ----- hdl/vuc_isq.sv -----
// Pipelined integer square root giving the velocity magnitude in Q12.
module vuc_isq import vuc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  output logic [15:0]        mag
);

  logic signed [31:0] sqx, sqy;
  isq_t st_r [CORD_STG+1];

  assign sqx = vel_x * vel_x;
  assign sqy = vel_y * vel_y;

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].n   <= 32'(sqx) + 32'(sqy);
      st_r[0].res <= '0;
      for (int s = 1; s <= CORD_STG; s++) begin
        st_r[s] <= isq_step(isq_step(st_r[s-1], STEPS_PER_STG * (s - 1)),
                            STEPS_PER_STG * (s - 1) + 1);
      end
    end
  end

  assign mag = st_r[CORD_STG].res[15:0];

endmodule

// ----- hdl/vuc_exp.sv -----
// Pipelined Horner series for e^r in Q30, three stages per term.
module vuc_exp import vuc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] arg,
  output logic [31:0] res
);

  logic [31:0] t_in [EXP_TERMS];
  logic [29:0] r_in [EXP_TERMS];
  logic [31:0] p_r  [EXP_TERMS];
  logic [31:0] q_r  [EXP_TERMS];
  logic [31:0] pb_r [EXP_TERMS];
  logic [31:0] t_r  [EXP_TERMS];
  logic [29:0] ra_r [EXP_TERMS];
  logic [29:0] rb_r [EXP_TERMS];
  logic [29:0] rc_r [EXP_TERMS-1];

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    // floor(p/n) from a reciprocal product, low by at most one
    localparam logic [32:0] MUL = 33'h1_0000_0000 / (EXP_TERMS - j);
    localparam logic [31:0] DIV = 32'(EXP_TERMS - j);
    logic [61:0] tr;
    logic [64:0] pm;
    logic [31:0] rem;

    if (j == 0) begin : g_first
      assign t_in[j] = Q30_ONE;
      assign r_in[j] = arg;
    end else begin : g_next
      assign t_in[j] = t_r[j-1];
      assign r_in[j] = rc_r[j-1];
    end

    assign tr  = 62'(t_in[j]) * 62'(r_in[j]);
    assign pm  = 65'(p_r[j]) * 65'(MUL);
    assign rem = pb_r[j] - q_r[j] * DIV;

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[j]  <= tr[61:30];
        ra_r[j] <= r_in[j];
        q_r[j]  <= pm[63:32];
        pb_r[j] <= p_r[j];
        rb_r[j] <= ra_r[j];
        t_r[j]  <= Q30_ONE + ((rem >= DIV) ? q_r[j] + 32'd1 : q_r[j]);
      end
    end

    if (j < EXP_TERMS - 1) begin : g_rpass
      always_ff @(posedge clk) begin
        if (en) rc_r[j] <= rb_r[j];
      end
    end
  end

  assign res = t_r[EXP_TERMS-1];

endmodule

// ----- hdl/velocity_to_unicycle_command_top.sv -----
// Top level of the velocity-to-unicycle command pipeline.
//
//   port group  | direction | handshake          | payload
//   in_         | input     | in_valid/in_stall  | robot_tag, vel_x, vel_y, heading
//   out_        | output    | out_valid/out_stall| robot_tag_out, linear_speed, angular_speed
//   cfg_        | input     | cfg_we             | cfg_index, cfg_data
//
// One word per cycle in, one word per cycle out while no finished word waits
// under out_stall; the pipe holds 9 CORDIC/square-root stages, 2 error stages,
// 36 Horner stages for the 12-term exponential and 3 output stages.
// rst_n clears valid bits and the four clamp registers to their defaults.
// The whole pipe freezes while a finished word waits under out_stall.
`include "velocity_to_unicycle_command_top_defines.svh"
module velocity_to_unicycle_command_top import vuc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_robot_tag,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [14:0] in_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_robot_tag_out,
  output logic signed [15:0] out_linear_speed,
  output logic signed [17:0] out_angular_speed,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  typedef struct packed {
    logic [7:0]         tag;
    logic signed [14:0] hd;
  } sd1_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] mag;
    logic        neg;
    logic        zero;
    logic [2:0]  k;
  } sd2_t;

  logic adv;
  logic [TOT_LAT-1:0] vld_r;
  logic [14:0] lin_max_r, lin_min_r, ang_max_r, ang_min_r;

  logic signed [24:0] dir;
  logic [15:0]        mag;
  sd1_t               sd1_r [FRONT_LAT];

  logic signed [24:0] hd256, err_raw, err_nxt, err_r;
  logic [7:0]         tag10_r;
  logic [15:0]        mag10_r;

  logic signed [24:0] err_abs;
  logic [31:0]        a30;
  logic [2:0]         k_nxt;
  logic [31:0]        r_full, rn_full;
  logic [29:0]        r_r, rn_r;
  sd2_t               sd2_nxt;
  sd2_t               sd2_r [EXP_LAT+1];

  logic [31:0] tp, tn;
  logic [35:0] epos, wm;
  logic [31:0] eneg;
  logic [17:0] wmag_r;
  logic [47:0] prod_r;
  logic [7:0]  tag48_r, tag49_r;
  logic        neg48_r, zero48_r;

  logic [47:0]        rnd;
  logic [17:0]        vv;
  logic [11:0]        lin_nxt, lin_pre_r;
  logic signed [17:0] ang_nxt, ang_pre_r;
  logic signed [18:0] lin_clamp, ang_clamp;

  logic [7:0]         out_tag_r;
  logic signed [15:0] out_lin_r;
  logic signed [17:0] out_ang_r;

  assign adv      = !(vld_r[TOT_LAT-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TOT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_max_r <= 15'd2048;
      lin_min_r <= 15'd205;
      ang_max_r <= 15'd8192;
      ang_min_r <= 15'd205;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LIN_MAX: lin_max_r <= cfg_data;
        CFG_LIN_MIN: lin_min_r <= cfg_data;
        CFG_ANG_MAX: ang_max_r <= cfg_data;
        CFG_ANG_MIN: ang_min_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vuc_cord u_cord (
    .clk   (clk),
    .en    (adv),
    .vel_x (in_vel_x),
    .vel_y (in_vel_y),
    .dir   (dir)
  );

  vuc_isq u_isq (
    .clk   (clk),
    .en    (adv),
    .vel_x (in_vel_x),
    .vel_y (in_vel_y),
    .mag   (mag)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sd1_r[0] <= '{tag: in_robot_tag, hd: in_heading};
      for (int s = 1; s < FRONT_LAT; s++) sd1_r[s] <= sd1_r[s-1];
    end
  end

  // heading error, wrapped once into [-pi, pi]
  always_comb begin
    hd256   = {{2{sd1_r[FRONT_LAT-1].hd[14]}}, sd1_r[FRONT_LAT-1].hd, 8'b0};
    err_raw = dir - hd256;
    err_nxt = err_raw;
    if (err_raw > Q20_PI) err_nxt = err_raw - Q20_TWO_PI;
    else if (err_raw < -Q20_PI) err_nxt = err_raw + Q20_TWO_PI;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err_r   <= err_nxt;
      tag10_r <= sd1_r[FRONT_LAT-1].tag;
      mag10_r <= mag;
    end
  end

  // |err| = k*ln2 + r; the negative exponent uses ln2 - r
  always_comb begin
    err_abs = err_r[24] ? -err_r : err_r;
    a30     = {err_abs[21:0], 10'b0};
    if (a30 >= KLN2[4])      k_nxt = 3'd4;
    else if (a30 >= KLN2[3]) k_nxt = 3'd3;
    else if (a30 >= KLN2[2]) k_nxt = 3'd2;
    else if (a30 >= KLN2[1]) k_nxt = 3'd1;
    else                     k_nxt = 3'd0;
    r_full  = a30 - KLN2[k_nxt];
    rn_full = KLN2[k_nxt + 3'd1] - a30;
    sd2_nxt.tag  = tag10_r;
    sd2_nxt.mag  = mag10_r;
    sd2_nxt.neg  = err_r[24];
    sd2_nxt.zero = (err_r == '0);
    sd2_nxt.k    = k_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r      <= r_full[29:0];
      rn_r     <= rn_full[29:0];
      sd2_r[0] <= sd2_nxt;
      for (int s = 1; s <= EXP_LAT; s++) sd2_r[s] <= sd2_r[s-1];
    end
  end

  vuc_exp u_exp_pos (
    .clk (clk),
    .en  (adv),
    .arg (r_r),
    .res (tp)
  );

  vuc_exp u_exp_neg (
    .clk (clk),
    .en  (adv),
    .arg (rn_r),
    .res (tn)
  );

  assign epos = 36'(tp) << sd2_r[EXP_LAT].k;
  assign eneg = tn >> (sd2_r[EXP_LAT].k + 3'd1);
  assign wm   = epos - 36'(Q30_ONE) + 36'h0_0002_0000;

  always_ff @(posedge clk) begin
    if (adv) begin
      wmag_r   <= wm[35:18];
      prod_r   <= 48'(sd2_r[EXP_LAT].mag) * 48'(eneg);
      tag48_r  <= sd2_r[EXP_LAT].tag;
      neg48_r  <= sd2_r[EXP_LAT].neg;
      zero48_r <= sd2_r[EXP_LAT].zero;
    end
  end

  // round to Q12, cap, and drop the turn when there is no forward speed or no heading error
  always_comb begin
    rnd     = prod_r + 48'h0000_2000_0000;
    vv      = rnd[47:30];
    lin_nxt = (vv > 18'(LIN_CAP)) ? LIN_CAP : vv[11:0];
    if (zero48_r || lin_nxt == '0) ang_nxt = '0;
    else if (neg48_r)              ang_nxt = -$signed(wmag_r);
    else                           ang_nxt = $signed(wmag_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lin_pre_r <= lin_nxt;
      ang_pre_r <= ang_nxt;
      tag49_r   <= tag48_r;
    end
  end

  assign lin_clamp = band_clamp($signed(19'(lin_pre_r)), lin_max_r, lin_min_r);
  assign ang_clamp = band_clamp(19'(ang_pre_r), ang_max_r, ang_min_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tag_r <= tag49_r;
      out_lin_r <= lin_clamp[15:0];
      out_ang_r <= ang_clamp[17:0];
    end
  end

  assign out_valid         = vld_r[TOT_LAT-1];
  assign out_robot_tag_out = out_tag_r;
  assign out_linear_speed  = out_lin_r;
  assign out_angular_speed = out_ang_r;

  `VUC_ASSERT_NXT(a_out_hold, clk, rst_n, !adv, out_valid)
  `VUC_ASSERT_IMP(a_r_range, clk, rst_n, vld_r[FRONT_LAT+1], r_r < Q30_LN2[29:0])
  `VUC_ASSERT_IMP(a_no_turn, clk, rst_n, vld_r[TOT_LAT-2] && lin_pre_r == '0, ang_pre_r == '0)

endmodule
